// File: rtl/core/vdlc_pkg.sv
// Shared constants and types of the vector distance block.
`timescale 1ns / 1ps
package vdlc_pkg;
  localparam int unsigned MaxDimDefault = 1024;
  localparam int unsigned ElemW = 16;
  localparam int unsigned DistW = 22;
  localparam int unsigned SsdW = 43;
  localparam int unsigned DotW = 42;
  localparam int unsigned NormW = 41;
  localparam int unsigned QDepth = 2;
  localparam logic [0:0] RegMetric = 1'b0;
  localparam logic [21:0] L2Max = 22'd2097152;
  localparam logic [21:0] OneQ15 = 22'd32768;

  // Finished accumulation handed from the front part to the back part.
  typedef struct packed {
    logic [SsdW-1:0]  ssd;
    logic [DotW-1:0]  dot;
    logic [NormW-1:0] na;
    logic [NormW-1:0] nb;
    logic             sat;
    logic             metric;
  } vdlc_job_t;
endpackage

// File: rtl/core/vdlc_if.sv
// Valid/ready channel interfaces for the input and result words.
`timescale 1ns / 1ps
interface vdlc_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] elem_a;
  logic signed [15:0] elem_b;
  logic               last_pair;
  modport source (output valid, elem_a, elem_b, last_pair, input ready);
  modport sink (input valid, elem_a, elem_b, last_pair, output ready);
endinterface

interface vdlc_out_if;
  logic        valid;
  logic        ready;
  logic [21:0] distance;
  logic        zero_norm;
  logic        saturated;
  modport source (output valid, distance, zero_norm, saturated, input ready);
  modport sink (input valid, distance, zero_norm, saturated, output ready);
endinterface

// File: rtl/core/vdlc_front.sv
// Front part: registered products, saturating accumulators and job hand-off.
`timescale 1ns / 1ps
module vdlc_front import vdlc_pkg::*; #(
  parameter int unsigned MAX_DIM = MaxDimDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               metric_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [15:0] elem_a_i,
  input  logic signed [15:0] elem_b_i,
  input  logic               last_pair_i,
  output logic               job_valid_o,
  input  logic               job_ready_i,
  output vdlc_job_t          job_o
);
  localparam int unsigned CntW = $clog2(MAX_DIM + 1);

  // Stage 1: products.
  logic             p_valid_q, p_last_q, p_skip_q;
  logic [32:0]      p_ssd_q;
  logic [31:0]      p_na_q, p_nb_q;
  logic signed [31:0] p_dot_q;
  logic [CntW-1:0]  cnt_q;
  logic [SsdW-1:0]  ssd_q;
  logic signed [DotW-1:0] dot_q;
  logic [NormW-1:0] na_q, nb_q;
  logic             sat_q;
  logic             hold;

  // Stage 2 must wait while a finished job cannot be handed over.
  assign hold = p_valid_q && p_last_q && !job_ready_i;
  assign in_ready_o = !hold;

  logic signed [16:0] diff;
  logic        acc_in;
  logic        take;
  assign take = in_valid_i && in_ready_o;
  assign diff = 17'(elem_a_i) - 17'(elem_b_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_valid_q <= 1'b0;
    end else if (!hold) begin
      p_valid_q <= take;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      p_last_q <= last_pair_i;
      p_ssd_q  <= 33'($signed(34'(diff) * 34'(diff)));
      p_na_q   <= 32'($signed(32'(elem_a_i) * 32'(elem_a_i)));
      p_nb_q   <= 32'($signed(32'(elem_b_i) * 32'(elem_b_i)));
      p_dot_q  <= 32'(elem_a_i) * 32'(elem_b_i);
    end
  end

  // Count gate applied in stage 2 with the running count.
  assign acc_in = p_valid_q && !hold;
  assign p_skip_q = (cnt_q >= CntW'(MAX_DIM));

  logic [SsdW:0]  ssd_s;
  logic [NormW:0] na_s, nb_s;
  logic signed [DotW:0] dot_s;
  logic [SsdW-1:0] ssd_n;
  logic [NormW-1:0] na_n, nb_n;
  logic signed [DotW-1:0] dot_n;
  logic sat_n;
  localparam logic signed [DotW:0] DotHi = (DotW+1)'((64'sd1 <<< 41) - 1);
  localparam logic signed [DotW:0] DotLo = -DotHi - 1;

  always_comb begin
    ssd_s = {1'b0, ssd_q} + (SsdW+1)'(p_ssd_q);
    na_s  = {1'b0, na_q} + (NormW+1)'(p_na_q);
    nb_s  = {1'b0, nb_q} + (NormW+1)'(p_nb_q);
    dot_s = (DotW+1)'(dot_q) + (DotW+1)'(p_dot_q);
    sat_n = sat_q;
    ssd_n = ssd_s[SsdW-1:0];
    na_n  = na_s[NormW-1:0];
    nb_n  = nb_s[NormW-1:0];
    dot_n = dot_s[DotW-1:0];
    if (ssd_s[SsdW]) begin
      ssd_n = '1;
      sat_n = 1'b1;
    end
    if (na_s[NormW]) begin
      na_n = '1;
      sat_n = 1'b1;
    end
    if (nb_s[NormW]) begin
      nb_n = '1;
      sat_n = 1'b1;
    end
    if (dot_s > DotHi) begin
      dot_n = DotW'(DotHi);
      sat_n = 1'b1;
    end else if (dot_s < DotLo) begin
      dot_n = DotW'(DotLo);
      sat_n = 1'b1;
    end
    if (p_skip_q) begin
      ssd_n = ssd_q;
      na_n  = na_q;
      nb_n  = nb_q;
      dot_n = dot_q;
      sat_n = 1'b1;
    end
  end

  assign job_valid_o = p_valid_q && p_last_q;
  assign job_o = '{ssd: ssd_n, dot: dot_n, na: na_n, nb: nb_n, sat: sat_n,
                   metric: metric_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      ssd_q <= '0;
      dot_q <= '0;
      na_q  <= '0;
      nb_q  <= '0;
      sat_q <= 1'b0;
    end else if (acc_in) begin
      if (p_last_q) begin
        cnt_q <= '0;
        ssd_q <= '0;
        dot_q <= '0;
        na_q  <= '0;
        nb_q  <= '0;
        sat_q <= 1'b0;
      end else begin
        if (!p_skip_q) begin
          cnt_q <= cnt_q + 1'b1;
        end
        ssd_q <= ssd_n;
        dot_q <= dot_n;
        na_q  <= na_n;
        nb_q  <= nb_n;
        sat_q <= sat_n;
      end
    end
  end
endmodule

// File: rtl/core/vdlc_queue.sv
// Short job queue between the front and back parts.
`timescale 1ns / 1ps
module vdlc_queue import vdlc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      wr_valid_i,
  output logic      wr_ready_o,
  input  vdlc_job_t wr_data_i,
  output logic      rd_valid_o,
  input  logic      rd_ready_i,
  output vdlc_job_t rd_data_o
);
  localparam int unsigned PtrW = $clog2(QDepth);
  vdlc_job_t     mem_q [QDepth];
  logic [PtrW-1:0] wp_q, rp_q;
  logic [PtrW:0]   cnt_q;
  logic wr, rd;

  assign wr_ready_o = cnt_q != (PtrW+1)'(QDepth);
  assign rd_valid_o = cnt_q != '0;
  assign rd_data_o  = mem_q[rp_q];
  assign wr = wr_valid_i && wr_ready_o;
  assign rd = rd_valid_o && rd_ready_i;

  always_ff @(posedge clk_i) begin
    if (wr) begin
      mem_q[wp_q] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (wr) begin
        wp_q <= wp_q + 1'b1;
      end
      if (rd) begin
        rp_q <= rp_q + 1'b1;
      end
      cnt_q <= cnt_q + (PtrW+1)'(wr) - (PtrW+1)'(rd);
    end
  end
endmodule

// File: rtl/core/vdlc_back.sv
// Back part: iterative square roots; cosine adds mul and restoring divide.
`timescale 1ns / 1ps
module vdlc_back import vdlc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             job_valid_i,
  output logic             job_ready_o,
  input  vdlc_job_t        job_i,
  output logic             res_valid_o,
  input  logic             res_ready_i,
  output logic [DistW-1:0] distance_o,
  output logic             zero_norm_o,
  output logic             saturated_o
);
  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StSqrt = 3'd1;
  localparam logic [2:0] StMul  = 3'd2;
  localparam logic [2:0] StDiv  = 3'd3;
  localparam logic [2:0] StFin  = 3'd4;
  localparam logic [2:0] StOut  = 3'd5;
  localparam int unsigned RW = 22;
  localparam int unsigned DivW = 57;

  logic [2:0] st_q;
  logic [5:0] it_q;
  logic       sel_q;     // which root: 0 first, 1 second
  logic       metric_q, sat_q, neg_q;
  logic [SsdW:0] rad_q;   // remaining radicand, even width
  logic [RW-1:0] root_q, ra_q;
  logic [SsdW:0] rem_q;
  logic [43:0] den_q;
  logic [DivW-1:0] num_q;
  logic [44:0] drem_q;
  logic [NormW-1:0] nb_q;
  logic [DotW-1:0] mag_q;

  // One root bit per cycle, two radicand bits shifted in.
  logic [SsdW+2:0] trial;
  logic [SsdW+2:0] rsh;
  assign rsh = {rem_q[SsdW:0], rad_q[SsdW:SsdW-1]};
  assign trial = rsh - {(SsdW+3-RW-2)'(0), root_q, 2'b01};

  logic [45:0] dtrial;
  assign dtrial = {drem_q, num_q[DivW-1]} - {2'b0, den_q};

  logic [DotW-1:0] dot_abs;
  assign dot_abs = job_i.dot[DotW-1] ? -job_i.dot : job_i.dot;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle;
      it_q <= '0;
    end else begin
      unique case (st_q)
        StIdle: begin
          if (job_valid_i) begin
            st_q <= StSqrt;
            it_q <= 6'd22;
          end
        end
        StSqrt: begin
          it_q <= it_q - 1'b1;
          if (it_q == 6'd1) begin
            if (!metric_q || sel_q) begin
              st_q <= metric_q ? StMul : StFin;
            end else begin
              it_q <= 6'd22;
            end
          end
        end
        StMul: begin
          st_q <= StDiv;
          it_q <= 6'(DivW);
        end
        StDiv: begin
          it_q <= it_q - 1'b1;
          if (it_q == 6'd1) begin
            st_q <= StFin;
          end
        end
        StFin: st_q <= StOut;
        StOut: begin
          if (res_ready_i) begin
            st_q <= StIdle;
          end
        end
        default: st_q <= StIdle;
      endcase
    end
  end

  assign job_ready_o = st_q == StIdle;
  assign res_valid_o = st_q == StOut;

  always_ff @(posedge clk_i) begin
    unique case (st_q)
      StIdle: begin
        metric_q <= job_i.metric;
        sat_q    <= job_i.sat;
        neg_q    <= job_i.dot[DotW-1];
        mag_q    <= dot_abs;
        nb_q     <= job_i.nb;
        sel_q    <= 1'b0;
        rad_q    <= job_i.metric ? (SsdW+1)'(job_i.na) : {1'b0, job_i.ssd};
        rem_q    <= '0;
        root_q   <= '0;
      end
      StSqrt: begin
        rad_q <= {rad_q[SsdW-2:0], 2'b00};
        if (!trial[SsdW+2]) begin
          rem_q  <= trial[SsdW:0];
          root_q <= {root_q[RW-2:0], 1'b1};
        end else begin
          rem_q  <= rsh[SsdW:0];
          root_q <= {root_q[RW-2:0], 1'b0};
        end
        if (it_q == 6'd1 && metric_q && !sel_q) begin
          sel_q  <= 1'b1;
          ra_q   <= {root_q[RW-2:0], !trial[SsdW+2]};
          rad_q  <= (SsdW+1)'(nb_q);
          rem_q  <= '0;
          root_q <= '0;
        end
      end
      StMul: begin
        den_q  <= 44'(ra_q) * 44'(root_q);
        num_q  <= {mag_q, 15'b0};
        drem_q <= '0;
      end
      StDiv: begin
        num_q <= {num_q[DivW-2:0], !dtrial[45]};
        drem_q <= dtrial[45] ? {drem_q[43:0], num_q[DivW-1]} : dtrial[44:0];
      end
      StFin: begin
        if (!metric_q) begin
          distance_o  <= (root_q > L2Max) ? L2Max : root_q;
          zero_norm_o <= 1'b0;
        end else if (den_q == '0) begin
          distance_o  <= OneQ15;
          zero_norm_o <= 1'b1;
        end else begin
          zero_norm_o <= 1'b0;
          if (num_q > DivW'(OneQ15)) begin
            distance_o <= neg_q ? 22'd65536 : 22'd0;
          end else begin
            distance_o <= neg_q ? OneQ15 + num_q[DistW-1:0] : OneQ15 - num_q[DistW-1:0];
          end
        end
        saturated_o <= sat_q;
      end
      default: ;
    endcase
  end
endmodule

// File: rtl/core/vector_distance_l2_cosine.sv
// Top level of the streaming Euclidean and cosine distance block.
// Unless stalled, the block takes one element pair per cycle and accumulates
// the sum of squared differences, the dot product and both squared norms with
// saturation; pairs past MAX_DIM are dropped and flag saturation. On the last
// pair the totals move into a two-entry queue, and a back end computes the
// result: Euclidean uses one 22-step square root, cosine uses two 22-step
// roots, a multiply and a 57-step restoring divide. Streaming runs at one
// word per cycle, except that a new vector's last pair waits only when the
// queue is full; the front part takes new vectors while the back end is busy.
`timescale 1ns / 1ps
module vector_distance_l2_cosine import vdlc_pkg::*; #(
  parameter int unsigned MAX_DIM = MaxDimDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  vdlc_in_if.sink     in_if,
  vdlc_out_if.source  out_if,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  logic metric_q;
  logic cfg_wr;

  // Register 0 sits at byte address 0; other addresses are ignored.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[1:0] == {RegMetric, 1'b0});
  assign prdata = (paddr == 2'd0) ? {31'b0, metric_q} : 32'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      metric_q <= 1'b0;
    end else if (cfg_wr) begin
      metric_q <= pwdata[0];
    end
  end

  logic      fj_valid, fj_ready, bj_valid, bj_ready;
  vdlc_job_t fj, bj;

  vdlc_front #(.MAX_DIM(MAX_DIM)) u_front (
    .clk_i, .rst_ni, .metric_i(metric_q),
    .in_valid_i(in_if.valid), .in_ready_o(in_if.ready),
    .elem_a_i(in_if.elem_a), .elem_b_i(in_if.elem_b), .last_pair_i(in_if.last_pair),
    .job_valid_o(fj_valid), .job_ready_i(fj_ready), .job_o(fj)
  );

  vdlc_queue u_queue (
    .clk_i, .rst_ni,
    .wr_valid_i(fj_valid), .wr_ready_o(fj_ready), .wr_data_i(fj),
    .rd_valid_o(bj_valid), .rd_ready_i(bj_ready), .rd_data_o(bj)
  );

  vdlc_back u_back (
    .clk_i, .rst_ni,
    .job_valid_i(bj_valid), .job_ready_o(bj_ready), .job_i(bj),
    .res_valid_o(out_if.valid), .res_ready_i(out_if.ready),
    .distance_o(out_if.distance), .zero_norm_o(out_if.zero_norm),
    .saturated_o(out_if.saturated)
  );
endmodule
